>>> src/tcm_pkg.sv
// Shared types and constants for the tilt correction matrix unit.
package tcm_pkg;

	localparam int SAMPLE_WIDTH      = 16;
	localparam int FRACTION_BITS_DEF = 14;
	localparam int NORM_WIDTH        = 16;
	localparam int QUEUE_DEPTH       = 4;

	typedef enum logic [1:0] {
		KIND_GENERAL = 2'd0,
		KIND_ALIGNED = 2'd1,
		KIND_FLIP    = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_SUM,
		ST_SQRT,
		ST_DSET,
		ST_DRUN,
		ST_DSTORE,
		ST_PROD,
		ST_DONE
	} back_state_t;

	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] grav_x;
		logic signed [SAMPLE_WIDTH-1:0] grav_y;
		logic signed [SAMPLE_WIDTH-1:0] grav_z;
	} tcm_in_t;

	typedef struct packed {
		logic signed [15:0] m00;
		logic signed [15:0] m01;
		logic signed [15:0] m02;
		logic signed [15:0] m10;
		logic signed [15:0] m11;
		logic signed [15:0] m12;
		logic signed [15:0] m20;
		logic signed [15:0] m21;
		logic signed [15:0] m22;
		kind_t              case_kind;
	} tcm_out_t;

	// scaled vector plus its class, as queued between front and back
	typedef struct packed {
		logic signed [NORM_WIDTH:0] nx;
		logic signed [NORM_WIDTH:0] ny;
		logic signed [NORM_WIDTH:0] nz;
		kind_t                      kind;
	} tcm_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} tcm_q_status_t;

endpackage

>>> src/tilt_correction_matrix_unit.sv
// Tilt correction matrix unit: rotation taking a gravity word onto +z.
// Zero, aligned and anti-parallel words pass through the front register, the queue and the output
// register, one special word per cycle while the engine is idle and the output is not stalled. A
// general word holds the engine for the bit-serial square root (31 steps) and six 32-step divisions.
// The front end keeps accepting into a four-entry queue while the engine works.
// Reset: arst_n clears control state asynchronously; the queue and output register come up empty.
module tilt_correction_matrix_unit #(
	parameter int FRACTION_BITS = tcm_pkg::FRACTION_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  tcm_pkg::tcm_in_t  in_word,
	output logic              out_valid,
	input  logic              out_ready,
	output tcm_pkg::tcm_out_t out_word
);
	import tcm_pkg::*;

	logic          push, pop;
	tcm_item_t     push_item, head;
	tcm_q_status_t q_status;

	tcm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.push      (push),
		.push_item (push_item),
		.q_status  (q_status)
	);

	tcm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.q_status  (q_status)
	);

	tcm_back #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_status  (q_status),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

endmodule

>>> src/tcm_front.sv
// Front end: accepts a gravity word, scales it and classifies it.
module tcm_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  tcm_pkg::tcm_in_t  in_word,
	output logic              push,
	output tcm_pkg::tcm_item_t push_item,
	input  tcm_pkg::tcm_q_status_t q_status
);
	import tcm_pkg::*;

	localparam int SW    = SAMPLE_WIDTH;
	localparam int NW    = NORM_WIDTH;
	localparam int LEN_W = $clog2(SW + 1);

	logic              valid_s1;
	tcm_item_t         item_s1;
	logic [SW-1:0]     mag_x, mag_y, mag_z, mag_m;
	logic [LEN_W-1:0]  len;
	logic [SW+NW-1:0]  wide_x, wide_y, wide_z;
	logic [NW-1:0]     s_x, s_y, s_z;
	tcm_item_t         item_c;

	always_comb begin
		mag_x = in_word.grav_x[SW-1] ? SW'(-in_word.grav_x) : SW'(in_word.grav_x);
		mag_y = in_word.grav_y[SW-1] ? SW'(-in_word.grav_y) : SW'(in_word.grav_y);
		mag_z = in_word.grav_z[SW-1] ? SW'(-in_word.grav_z) : SW'(in_word.grav_z);
		mag_m = mag_x;
		if (mag_y > mag_m) begin
			mag_m = mag_y;
		end
		if (mag_z > mag_m) begin
			mag_m = mag_z;
		end
		len = '0;
		for (int i = 0; i < SW; i++) begin
			if (mag_m[i]) begin
				len = LEN_W'(i + 1);
			end
		end
		// top bit lands at position NW-1, exact left or truncating right shift
		wide_x = {mag_x, {NW{1'b0}}} >> len;
		wide_y = {mag_y, {NW{1'b0}}} >> len;
		wide_z = {mag_z, {NW{1'b0}}} >> len;
		s_x = wide_x[NW-1:0];
		s_y = wide_y[NW-1:0];
		s_z = wide_z[NW-1:0];
		item_c.nx = in_word.grav_x[SW-1] ? -$signed({1'b0, s_x}) : $signed({1'b0, s_x});
		item_c.ny = in_word.grav_y[SW-1] ? -$signed({1'b0, s_y}) : $signed({1'b0, s_y});
		item_c.nz = in_word.grav_z[SW-1] ? -$signed({1'b0, s_z}) : $signed({1'b0, s_z});
		if (mag_m == '0) begin
			item_c.kind = KIND_ALIGNED;
		end else if (s_x == '0 && s_y == '0) begin
			item_c.kind = in_word.grav_z[SW-1] ? KIND_FLIP : KIND_ALIGNED;
		end else begin
			item_c.kind = KIND_GENERAL;
		end
	end

	assign in_ready  = !valid_s1 || !q_status.full;
	assign push      = valid_s1;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= item_c;
		end
	end

endmodule

>>> src/tcm_queue.sv
// Short queue between the front end and the matrix engine.
module tcm_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  tcm_pkg::tcm_item_t     push_item,
	input  logic                   pop,
	output tcm_pkg::tcm_item_t     head,
	output tcm_pkg::tcm_q_status_t q_status
);
	import tcm_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);

	tcm_item_t     slot_q [QUEUE_DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   cnt_q;
	logic          do_push, do_pop;

	assign q_status.full  = cnt_q == (AW+1)'(QUEUE_DEPTH);
	assign q_status.empty = cnt_q == '0;
	assign do_push = push && !q_status.full;
	assign do_pop  = pop && !q_status.empty;
	assign head    = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!do_push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_item;
		end
	end

endmodule

>>> src/tcm_back.sv
// Matrix engine: sequenced multiplier, square root and divider, output register.
module tcm_back #(
	parameter int FRACTION_BITS = tcm_pkg::FRACTION_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  tcm_pkg::tcm_item_t     head,
	input  tcm_pkg::tcm_q_status_t q_status,
	output logic                   pop,
	output logic                   out_valid,
	input  logic                   out_ready,
	output tcm_pkg::tcm_out_t      out_word
);
	import tcm_pkg::*;

	localparam int SH = 30 - FRACTION_BITS;
	localparam logic signed [33:0] ONE_W = 34'sd1073741824;
	localparam logic [31:0] ONE_U = 32'd1073741824;

	function automatic logic [15:0] to_out(input logic signed [33:0] v);
		logic [33:0] mag;
		logic [33:0] r;
		logic [33:0] sres;
		mag = v[33] ? 34'(-v) : 34'(v);
		r = (mag + (34'd1 << (SH - 1))) >> SH;
		if (r > (34'd1 << FRACTION_BITS)) begin
			r = 34'd1 << FRACTION_BITS;
		end
		sres = v[33] ? 34'(-r) : r;
		return sres[15:0];
	endfunction

	back_state_t st_q, st_d;
	logic [5:0]  cnt_q;
	logic [2:0]  didx_q;
	tcm_item_t   item_q;
	logic [32:0] sqx_q, sqy_q, sqz_q;
	logic signed [33:0] pxy_q;
	logic [33:0] p_q;
	logic [61:0] x_sh_q;
	logic [32:0] srem_q;
	logic [30:0] root_q, lf_q;
	logic [33:0] drem_q, dden_q;
	logic [31:0] dnum_q, dquo_q;
	logic        dneg_q;
	logic signed [31:0] ax_q, ay_q, c_q, rxx_q, ryy_q, rxy_q;
	logic signed [65:0] prod_q;
	logic signed [32:0] qxx_q, qyy_q, qxy_q;
	logic        out_valid_q;
	tcm_out_t    out_q;

	logic        slot_free, load_out;
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mul_p;
	logic [34:0] s_rem4, s_trial;
	logic        s_ge;
	logic [33:0] d_den;
	logic [15:0] n_mag;
	logic [32:0] pxy_mag;
	logic [63:0] d_num, d_numa;
	logic [34:0] d_t;
	logic        d_ge;
	logic [31:0] d_val;
	logic signed [31:0] d_res;
	logic [65:0] p_mag;
	logic [65:0] p_rnd;
	logic signed [32:0] q_res;
	logic signed [32:0] omc;
	tcm_out_t    res_c;

	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: begin
				if (!q_status.empty && head.kind == KIND_GENERAL) begin
					st_d = ST_MUL;
				end
			end
			ST_MUL: begin
				if (cnt_q == 6'd3) begin
					st_d = ST_SUM;
				end
			end
			ST_SUM: st_d = ST_SQRT;
			ST_SQRT: begin
				if (cnt_q == 6'd30) begin
					st_d = ST_DSET;
				end
			end
			ST_DSET: st_d = ST_DRUN;
			ST_DRUN: begin
				if (cnt_q == 6'd31) begin
					st_d = ST_DSTORE;
				end
			end
			ST_DSTORE: st_d = (didx_q == 3'd5) ? ST_PROD : ST_DSET;
			ST_PROD: begin
				if (cnt_q == 6'd3) begin
					st_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (slot_free) begin
					st_d = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		pop = 1'b0;
		load_out = 1'b0;
		case (st_q)
			ST_IDLE: begin
				pop = !q_status.empty && (head.kind == KIND_GENERAL || slot_free);
				load_out = !q_status.empty && head.kind != KIND_GENERAL && slot_free;
			end
			ST_DONE: load_out = slot_free;
			default: begin
				pop = 1'b0;
				load_out = 1'b0;
			end
		endcase
	end

	// shared multiplier
	always_comb begin
		omc = 33'sd1073741824 - $signed({c_q[31], c_q});
		mul_a = $signed({{16{item_q.nx[16]}}, item_q.nx});
		mul_b = $signed({{16{item_q.nx[16]}}, item_q.nx});
		if (st_q == ST_MUL) begin
			case (cnt_q[1:0])
				2'd1: begin
					mul_a = $signed({{16{item_q.ny[16]}}, item_q.ny});
					mul_b = mul_a;
				end
				2'd2: begin
					mul_a = $signed({{16{item_q.nz[16]}}, item_q.nz});
					mul_b = mul_a;
				end
				2'd3: mul_b = $signed({{16{item_q.ny[16]}}, item_q.ny});
				default: mul_b = mul_a;
			endcase
		end else begin
			case (cnt_q[1:0])
				2'd0: mul_a = $signed({rxx_q[31], rxx_q});
				2'd1: mul_a = $signed({ryy_q[31], ryy_q});
				default: mul_a = $signed({rxy_q[31], rxy_q});
			endcase
			mul_b = omc;
		end
		mul_p = mul_a * mul_b;
	end

	// square root step, divider setup and step, product rounding
	always_comb begin
		s_rem4  = {srem_q, x_sh_q[61:60]};
		s_trial = {2'b00, root_q, 2'b01};
		s_ge    = s_rem4 >= s_trial;

		d_den = (didx_q < 3'd3) ? {3'b000, lf_q} : p_q;
		case (didx_q)
			3'd0: n_mag = item_q.nx[16] ? 16'(-item_q.nx) : item_q.nx[15:0];
			3'd1: n_mag = item_q.ny[16] ? 16'(-item_q.ny) : item_q.ny[15:0];
			default: n_mag = item_q.nz[16] ? 16'(-item_q.nz) : item_q.nz[15:0];
		endcase
		pxy_mag = pxy_q[33] ? 33'(-pxy_q) : pxy_q[32:0];
		case (didx_q)
			3'd3: d_num = {1'b0, sqx_q, 30'b0};
			3'd4: d_num = {1'b0, sqy_q, 30'b0};
			3'd5: d_num = {1'b0, pxy_mag, 30'b0};
			default: d_num = {4'b0000, n_mag, 44'b0};
		endcase
		d_numa = d_num + {30'b0, d_den[33:1]};

		d_t  = {drem_q, dnum_q[31]};
		d_ge = d_t >= {1'b0, dden_q};

		d_val = dquo_q;
		if (didx_q < 3'd3 && dquo_q > ONE_U) begin
			d_val = ONE_U;
		end
		d_res = dneg_q ? -$signed(d_val) : $signed(d_val);

		p_mag = prod_q[65] ? 66'(-prod_q) : 66'(prod_q);
		p_rnd = (p_mag + (66'd1 << 29)) >> 30;
		q_res = prod_q[65] ? -$signed(p_rnd[32:0]) : $signed(p_rnd[32:0]);
	end

	// result assembly
	always_comb begin
		if (st_q == ST_IDLE) begin
			res_c = '0;
			res_c.m00 = to_out(ONE_W);
			res_c.m11 = (head.kind == KIND_FLIP) ? to_out(-ONE_W) : to_out(ONE_W);
			res_c.m22 = res_c.m11;
			res_c.case_kind = head.kind;
		end else begin
			res_c.m00 = to_out(ONE_W - $signed({qxx_q[32], qxx_q}));
			res_c.m01 = to_out(-$signed({qxy_q[32], qxy_q}));
			res_c.m02 = to_out(-$signed({{2{ax_q[31]}}, ax_q}));
			res_c.m10 = res_c.m01;
			res_c.m11 = to_out(ONE_W - $signed({qyy_q[32], qyy_q}));
			res_c.m12 = to_out(-$signed({{2{ay_q[31]}}, ay_q}));
			res_c.m20 = to_out($signed({{2{ax_q[31]}}, ax_q}));
			res_c.m21 = to_out($signed({{2{ay_q[31]}}, ay_q}));
			res_c.m22 = to_out($signed({{2{c_q[31]}}, c_q}));
			res_c.case_kind = KIND_GENERAL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= res_c;
		end
		case (st_q)
			ST_IDLE: begin
				item_q <= head;
				cnt_q  <= '0;
			end
			ST_MUL: begin
				case (cnt_q[1:0])
					2'd0: sqx_q <= mul_p[32:0];
					2'd1: sqy_q <= mul_p[32:0];
					2'd2: sqz_q <= mul_p[32:0];
					default: pxy_q <= mul_p[33:0];
				endcase
				cnt_q <= cnt_q + 1'b1;
			end
			ST_SUM: begin
				p_q    <= {1'b0, sqx_q} + {1'b0, sqy_q};
				x_sh_q <= {({1'b0, sqx_q} + {1'b0, sqy_q} + {1'b0, sqz_q}), 28'b0};
				srem_q <= '0;
				root_q <= '0;
				cnt_q  <= '0;
			end
			ST_SQRT: begin
				if (s_ge) begin
					srem_q <= 33'(s_rem4 - s_trial);
					root_q <= {root_q[29:0], 1'b1};
				end else begin
					srem_q <= s_rem4[32:0];
					root_q <= {root_q[29:0], 1'b0};
				end
				x_sh_q <= {x_sh_q[59:0], 2'b00};
				if (cnt_q == 6'd30) begin
					lf_q <= {root_q[29:0], s_ge};
				end
				cnt_q  <= cnt_q + 1'b1;
				didx_q <= '0;
			end
			ST_DSET: begin
				drem_q <= {2'b00, d_numa[63:32]};
				dnum_q <= d_numa[31:0];
				dden_q <= d_den;
				dquo_q <= '0;
				case (didx_q)
					3'd0: dneg_q <= item_q.nx[16];
					3'd1: dneg_q <= item_q.ny[16];
					3'd2: dneg_q <= item_q.nz[16];
					3'd5: dneg_q <= pxy_q[33];
					default: dneg_q <= 1'b0;
				endcase
				cnt_q <= '0;
			end
			ST_DRUN: begin
				drem_q <= d_ge ? 34'(d_t - {1'b0, dden_q}) : d_t[33:0];
				dnum_q <= {dnum_q[30:0], 1'b0};
				dquo_q <= {dquo_q[30:0], d_ge};
				cnt_q  <= cnt_q + 1'b1;
			end
			ST_DSTORE: begin
				case (didx_q)
					3'd0: ax_q <= d_res;
					3'd1: ay_q <= d_res;
					3'd2: c_q <= d_res;
					3'd3: rxx_q <= d_res;
					3'd4: ryy_q <= d_res;
					default: rxy_q <= d_res;
				endcase
				didx_q <= didx_q + 1'b1;
				cnt_q  <= '0;
			end
			ST_PROD: begin
				prod_q <= mul_p;
				case (cnt_q[1:0])
					2'd1: qxx_q <= q_res;
					2'd2: qyy_q <= q_res;
					2'd3: qxy_q <= q_res;
					default: qxx_q <= qxx_q;
				endcase
				cnt_q <= cnt_q + 1'b1;
			end
			default: cnt_q <= cnt_q;
		endcase
	end

endmodule

>>> src/tcm_checker.sv
// Port checker for the tilt correction matrix unit, bound to the top level.
module tcm_port_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input tcm_pkg::tcm_out_t out_word
);
	import tcm_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_word))
		else $error("output word changed while stalled");

	a_symmetric: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_word.m01 == out_word.m10)
		else $error("m01 and m10 differ");

	a_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.case_kind == KIND_ALIGNED |->
			out_word.m01 == 16'sd0 && out_word.m02 == 16'sd0 && out_word.m12 == 16'sd0 &&
			out_word.m20 == 16'sd0 && out_word.m21 == 16'sd0 &&
			out_word.m00 == out_word.m11 && out_word.m11 == out_word.m22)
		else $error("aligned word is not the identity");

	a_flip: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.case_kind == KIND_FLIP |->
			out_word.m01 == 16'sd0 && out_word.m02 == 16'sd0 && out_word.m12 == 16'sd0 &&
			out_word.m20 == 16'sd0 && out_word.m21 == 16'sd0 &&
			out_word.m11 == out_word.m22 && 16'(out_word.m11 + out_word.m00) == 16'sd0)
		else $error("flip word is not diag(1,-1,-1)");

endmodule

bind tilt_correction_matrix_unit tcm_port_checker u_tcm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_word  (out_word)
);

>>> sim/tcm_checker.sv
// Checker for the tilt correction matrix unit: predicts each result word and compares it.
module tcm_checker #(
	parameter int FRACTION_BITS = tcm_pkg::FRACTION_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  tcm_pkg::tcm_in_t  in_word,
	input  logic              out_valid,
	input  logic              out_ready,
	input  tcm_pkg::tcm_out_t out_word,
	output int                fail_count,
	output int                pending
);
	import tcm_pkg::*;

	localparam longint ONE_Q30 = 64'sd1 << 30;

	tcm_out_t matrix_q[$];

	function automatic longint round_div(longint num, longint unsigned den);
		longint unsigned mag;
		longint unsigned q;
		mag = (num < 0) ? longint'(-num) : longint'(num);
		q = (mag + den / 2) / den;
		return (num < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint clamp_unit(longint v);
		if (v > ONE_Q30) return ONE_Q30;
		if (v < -ONE_Q30) return -ONE_Q30;
		return v;
	endfunction

	function automatic logic [15:0] to_fixed(longint q30);
		longint lim;
		longint v;
		lim = 64'sd1 << FRACTION_BITS;
		v = round_div(q30, 64'd1 << (30 - FRACTION_BITS));
		if (v > lim) v = lim;
		if (v < -lim) v = -lim;
		return v[15:0];
	endfunction

	function automatic tcm_out_t diag_matrix(longint d0, longint d1, longint d2, kind_t k);
		tcm_out_t r;
		r = '0;
		r.m00 = to_fixed(d0);
		r.m11 = to_fixed(d1);
		r.m22 = to_fixed(d2);
		r.case_kind = k;
		return r;
	endfunction

	function automatic tcm_out_t rotation_to_z(tcm_in_t w);
		longint g[3];
		longint n[3];
		longint mag[3];
		longint m;
		longint p, nn, ax, ay, c, rxx, ryy, rxy, omc, qxx, qyy, qxy;
		longint unsigned lf;
		int len;
		tcm_out_t r;
		g[0] = longint'(w.grav_x);
		g[1] = longint'(w.grav_y);
		g[2] = longint'(w.grav_z);
		m = 0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = (g[i] < 0) ? -g[i] : g[i];
			if (mag[i] > m) m = mag[i];
		end
		if (m == 0) return diag_matrix(ONE_Q30, ONE_Q30, ONE_Q30, KIND_ALIGNED);
		len = 0;
		while (len < 64 && (m >> len) != 0) len++;
		for (int i = 0; i < 3; i++) begin
			longint s;
			s = (len < 16) ? (mag[i] << (16 - len)) : (mag[i] >> (len - 16));
			n[i] = (g[i] < 0) ? -s : s;
		end
		if (n[0] == 0 && n[1] == 0) begin
			if (n[2] > 0) return diag_matrix(ONE_Q30, ONE_Q30, ONE_Q30, KIND_ALIGNED);
			return diag_matrix(ONE_Q30, -ONE_Q30, -ONE_Q30, KIND_FLIP);
		end
		p = n[0] * n[0] + n[1] * n[1];
		nn = p + n[2] * n[2];
		lf = int_sqrt(longint'(nn) << 28);
		ax = clamp_unit(round_div(n[0] * (64'sd1 << 44), lf));
		ay = clamp_unit(round_div(n[1] * (64'sd1 << 44), lf));
		c = clamp_unit(round_div(n[2] * (64'sd1 << 44), lf));
		rxx = round_div(n[0] * n[0] * ONE_Q30, p);
		ryy = round_div(n[1] * n[1] * ONE_Q30, p);
		rxy = round_div(n[0] * n[1] * ONE_Q30, p);
		omc = ONE_Q30 - c;
		qxx = round_div(rxx * omc, ONE_Q30);
		qyy = round_div(ryy * omc, ONE_Q30);
		qxy = round_div(rxy * omc, ONE_Q30);
		r.m00 = to_fixed(ONE_Q30 - qxx);
		r.m01 = to_fixed(-qxy);
		r.m02 = to_fixed(-ax);
		r.m10 = to_fixed(-qxy);
		r.m11 = to_fixed(ONE_Q30 - qyy);
		r.m12 = to_fixed(-ay);
		r.m20 = to_fixed(ax);
		r.m21 = to_fixed(ay);
		r.m22 = to_fixed(c);
		r.case_kind = KIND_GENERAL;
		return r;
	endfunction

	function automatic int field_bad(string name, logic [15:0] exp_v, logic [15:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0d, got %0d", name, $signed(exp_v), $signed(act_v));
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fail_count <= 0;
			pending    <= 0;
		end else begin
			tcm_out_t e;
			int bad;
			bad = 0;
			if (in_valid && in_ready) matrix_q.push_back(rotation_to_z(in_word));
			if (out_valid && out_ready) begin
				if (matrix_q.size() == 0) begin
					$error("unexpected result word");
					bad = 1;
				end else begin
					e = matrix_q.pop_front();
					bad += field_bad("m00", e.m00, out_word.m00);
					bad += field_bad("m01", e.m01, out_word.m01);
					bad += field_bad("m02", e.m02, out_word.m02);
					bad += field_bad("m10", e.m10, out_word.m10);
					bad += field_bad("m11", e.m11, out_word.m11);
					bad += field_bad("m12", e.m12, out_word.m12);
					bad += field_bad("m20", e.m20, out_word.m20);
					bad += field_bad("m21", e.m21, out_word.m21);
					bad += field_bad("m22", e.m22, out_word.m22);
					if (e.case_kind !== out_word.case_kind) begin
						$error("case_kind: expected %0d, got %0d", e.case_kind,
							out_word.case_kind);
						bad++;
					end
				end
			end
			fail_count <= fail_count + bad;
			pending    <= matrix_q.size();
		end
	end

endmodule

>>> sim/tb_tilt_correction_matrix_unit.sv
// Testbench top for the tilt correction matrix unit: stimulus, handshake idling and verdict.
module tb_tilt_correction_matrix_unit;
	import tcm_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     in_valid = 1'b0;
	logic     in_ready;
	tcm_in_t  in_word = '0;
	logic     out_valid;
	logic     out_ready = 1'b0;
	tcm_out_t out_word;
	int       fail_count;
	int       pending;
	int       idle_pct = 0;
	int       stall_pct = 0;
	int       hold_req = 0;
	int       quiet_cycles = 0;

	always #6 clk = ~clk;

	tilt_correction_matrix_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
		.out_valid(out_valid), .out_ready(out_ready), .out_word(out_word)
	);

	tcm_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
		.out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
		.fail_count(fail_count), .pending(pending)
	);

	// receiver: random stalls, plus a long hold-off when requested
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic send_word(logic [15:0] x, logic [15:0] y, logic [15:0] z);
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		in_valid <= 1'b1;
		in_word  <= '{grav_x: x, grav_y: y, grav_z: z};
		@(negedge clk);
		while (!in_ready) @(negedge clk);
		@(posedge clk);
	endtask

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(5))
			0: return 16'($signed($urandom_range(8)) - 4);
			1: return 16'($signed($urandom_range(512)) - 256);
			2: return $urandom_range(1) ? 16'h8000 : 16'h7fff;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_random();
		logic [15:0] x, y, z;
		x = pick_sample();
		y = pick_sample();
		z = pick_sample();
		case ($urandom_range(9))
			0: begin x = '0; y = '0; end
			1: begin x = '0; y = '0; z = '0; end
			2: x = '0;
			3: y = '0;
			default: ;
		endcase
		send_word(x, y, z);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// special cases and field extremes
		send_word(16'h0000, 16'h0000, 16'h0000);
		send_word(16'h0000, 16'h0000, 16'h0001);
		send_word(16'h0000, 16'h0000, 16'h7fff);
		send_word(16'h0000, 16'h0000, 16'hffff);
		send_word(16'h0000, 16'h0000, 16'h8000);
		send_word(16'h0001, 16'h0000, 16'h0000);
		send_word(16'h0000, 16'hffff, 16'h0000);
		send_word(16'h8000, 16'h8000, 16'h8000);
		send_word(16'h7fff, 16'h7fff, 16'h7fff);
		send_word(16'h8000, 16'h7fff, 16'h0000);
		send_word(16'h7fff, 16'h8000, 16'h8000);
		send_word(16'h0001, 16'h0001, 16'h7fff);
		send_word(16'hffff, 16'h0001, 16'h8000);
		send_word(16'h0001, 16'h0000, 16'h8000);
		send_word(16'hffff, 16'hffff, 16'hffff);
		send_word(16'h4000, 16'hc000, 16'h2000);

		// long receiver hold-off with the sender pushing
		hold_req = 800;
		for (int i = 0; i < 20; i++) send_random();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 54; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 54; end
				default: begin idle_pct = 27; stall_pct = 27; end
			endcase
			for (int i = 0; i < 450; i++) send_random();
		end
		in_valid <= 1'b0;
		@(posedge clk);

		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
